// ----- rtl/core/lgs_pkg.sv -----
// Shared types, constants and helpers for the life generation step block.
`timescale 1ns / 1ps

package lgs_pkg;

   localparam int MAX_ROWS      = 64;
   localparam int MAX_COLS      = 64;
   localparam int ROW_AW        = $clog2(MAX_ROWS);
   localparam int COL_AW        = $clog2(MAX_COLS);
   localparam int SIZE_W        = 7;
   localparam int COORD_W       = 6;
   localparam int CSR_IDX_W     = 2;
   localparam int BIRTH_COUNT   = 3;
   localparam int SURVIVE_COUNT = 2;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_STEP  = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS = 2'd0,
      CSR_COLS = 2'd1,
      CSR_WRAP = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic [SIZE_W-1:0] cols;
      logic [COL_AW-1:0] last_col;
      logic              wrap;
   } row_cfg_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] max);
      logic [SIZE_W-1:0] res;
      if (v == '0) begin
         res = SIZE_W'(1);
      end else if (v > max) begin
         res = max;
      end else begin
         res = v;
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/life_generation_step.sv -----
// Top level: B3/S23 board with cell write, cell read and generation step commands.
//
//   channel   direction  handshake             payload
//   req       in         req_tvalid/tready     tuser: command; tdata: row, col, cell_value
//   rsp       out        rsp_tvalid/tready     tdata: cell_alive; tuser: out_of_range
//   csr       in         csr_we                csr_index, csr_wdata
//
// Cell write and read: accept, RAM read and write-back, post the word.
// Step: accept, load row 0, last row and row 1, sweep the rows in use, post; the single RAM
// read port feeds one row per cycle through the row update unit, which writes the row back
// the same cycle.
// The block takes one command at a time; an unused command code answers with zeros.
// Synchronous reset clears the board via per-row valid bits, loads the size registers
// and holds req_tready low.
// A result held by rsp_tready low stalls only the final state of the next command.
`timescale 1ns / 1ps

module life_generation_step (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [15:0]                        req_tdata,  // row, col, cell_value
   input  logic [1:0]                         req_tuser,  // command
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata,  // cell_alive
   output logic                               rsp_tuser,  // out_of_range
   input  logic                               csr_we,
   input  logic [lgs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lgs_pkg::SIZE_W-1:0]         csr_wdata
);
   import lgs_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE       = 7'b0000001,
      S_ACCESS     = 7'b0000010,
      S_LOAD_FIRST = 7'b0000100,
      S_LOAD_LAST  = 7'b0001000,
      S_PRIME      = 7'b0010000,
      S_SWEEP      = 7'b0100000,
      S_DONE       = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   logic [SIZE_W-1:0]      rows_cfg_ff, rows_cfg_in;
   logic [SIZE_W-1:0]      cols_cfg_ff, cols_cfg_in;
   logic                   wrap_ff, wrap_in;
   logic                   valid_ff [MAX_ROWS];
   logic                   rd_valid_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_alive_ff, rsp_alive_in;
   logic                   rsp_oor_ff, rsp_oor_in;
   logic                   res_alive_ff, res_alive_in;
   logic                   res_oor_ff, res_oor_in;
   logic [ROW_AW-1:0]      lat_row_ff, lat_row_in;
   logic [COL_AW-1:0]      lat_col_ff, lat_col_in;
   logic                   lat_val_ff, lat_val_in;
   logic                   lat_oor_ff, lat_oor_in;
   cmd_type                lat_cmd_ff, lat_cmd_in;
   logic [ROW_AW-1:0]      row_cnt_ff, row_cnt_in;
   logic [MAX_COLS-1:0]    above_ff, above_in;
   logic [MAX_COLS-1:0]    cur_ff, cur_in;
   logic [MAX_COLS-1:0]    first_ff, first_in;

   logic [SIZE_W-1:0]      rows_eff, cols_eff;
   logic [ROW_AW-1:0]      last_row;
   logic [COORD_W-1:0]     req_row, req_col;
   logic                   req_val;
   logic                   req_oor;
   logic                   req_fire;
   logic                   out_free;
   logic [ROW_AW-1:0]      rd_addr;
   logic [MAX_COLS-1:0]    ram_q;
   logic [MAX_COLS-1:0]    row_data;
   logic [MAX_COLS-1:0]    below;
   logic [MAX_COLS-1:0]    next_row;
   logic [MAX_COLS-1:0]    cell_mask;
   logic                   wr_en;
   logic [ROW_AW-1:0]      wr_addr;
   logic [MAX_COLS-1:0]    wr_data;
   row_cfg_type            unit_cfg;

   assign rows_eff = clamp_size(rows_cfg_ff, SIZE_W'(MAX_ROWS));
   assign cols_eff = clamp_size(cols_cfg_ff, SIZE_W'(MAX_COLS));
   assign last_row = ROW_AW'(rows_eff - SIZE_W'(1));

   assign req_row  = req_tdata[5:0];
   assign req_col  = req_tdata[11:6];
   assign req_val  = req_tdata[12];
   assign req_oor  = (SIZE_W'(req_row) >= rows_eff) || (SIZE_W'(req_col) >= cols_eff);

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign row_data  = rd_valid_ff ? ram_q : '0;
   assign below     = (row_cnt_ff == last_row) ? (wrap_ff ? first_ff : '0) : row_data;
   assign cell_mask = MAX_COLS'(1) << lat_col_ff;

   assign unit_cfg.cols     = cols_eff;
   assign unit_cfg.last_col = COL_AW'(cols_eff - SIZE_W'(1));
   assign unit_cfg.wrap     = wrap_ff;

   lgs_row_unit u_row_unit (
      .cfg      (unit_cfg),
      .above    (above_ff),
      .cur      (cur_ff),
      .below    (below),
      .next_row (next_row)
   );

   lgs_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
   ) u_board (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      case (state_ff)
         S_IDLE:       rd_addr = ROW_AW'(req_row);
         S_LOAD_FIRST: rd_addr = '0;
         S_LOAD_LAST:  rd_addr = last_row;
         S_PRIME:      rd_addr = ROW_AW'(1);
         S_SWEEP:      rd_addr = row_cnt_ff + ROW_AW'(2);
         default:      rd_addr = lat_row_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = row_cnt_ff;
      wr_data = next_row;
      if (state_ff == S_ACCESS) begin
         wr_en   = (lat_cmd_ff == CMD_WRITE) && !lat_oor_ff;
         wr_addr = lat_row_ff;
         wr_data = lat_val_ff ? (row_data | cell_mask) : (row_data & ~cell_mask);
      end else if (state_ff == S_SWEEP) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      rows_cfg_in  = rows_cfg_ff;
      cols_cfg_in  = cols_cfg_ff;
      wrap_in      = wrap_ff;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_alive_in = rsp_alive_ff;
      rsp_oor_in   = rsp_oor_ff;
      res_alive_in = res_alive_ff;
      res_oor_in   = res_oor_ff;
      lat_row_in   = lat_row_ff;
      lat_col_in   = lat_col_ff;
      lat_val_in   = lat_val_ff;
      lat_oor_in   = lat_oor_ff;
      lat_cmd_in   = lat_cmd_ff;
      row_cnt_in   = row_cnt_ff;
      above_in     = above_ff;
      cur_in       = cur_ff;
      first_in     = first_ff;

      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_ROWS: rows_cfg_in = csr_wdata;
            CSR_COLS: cols_cfg_in = csr_wdata;
            CSR_WRAP: wrap_in     = csr_wdata[0];
            default:  ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               lat_row_in   = ROW_AW'(req_row);
               lat_col_in   = COL_AW'(req_col);
               lat_val_in   = req_val;
               lat_oor_in   = req_oor;
               lat_cmd_in   = cmd_type'(req_tuser);
               res_alive_in = 1'b0;
               res_oor_in   = 1'b0;
               case (cmd_type'(req_tuser))
                  CMD_WRITE: state_in = S_ACCESS;
                  CMD_READ:  state_in = S_ACCESS;
                  CMD_STEP:  state_in = S_LOAD_FIRST;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_ACCESS: begin
            res_oor_in   = lat_oor_ff;
            res_alive_in = (lat_cmd_ff == CMD_READ) && !lat_oor_ff && row_data[lat_col_ff];
            state_in     = S_DONE;
         end
         S_LOAD_FIRST: begin
            state_in = S_LOAD_LAST;
         end
         S_LOAD_LAST: begin
            first_in = row_data;
            cur_in   = row_data;
            state_in = S_PRIME;
         end
         S_PRIME: begin
            above_in   = wrap_ff ? row_data : '0;
            row_cnt_in = '0;
            state_in   = S_SWEEP;
         end
         S_SWEEP: begin
            above_in   = cur_ff;
            cur_in     = row_data;
            row_cnt_in = row_cnt_ff + ROW_AW'(1);
            if (row_cnt_ff == last_row) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_alive_in = res_alive_ff;
               rsp_oor_in   = res_oor_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rows_cfg_ff  <= SIZE_W'(64);
         cols_cfg_ff  <= SIZE_W'(64);
         wrap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_ROWS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rows_cfg_ff  <= rows_cfg_in;
         cols_cfg_ff  <= cols_cfg_in;
         wrap_ff      <= wrap_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff  <= valid_ff[rd_addr];
      rsp_alive_ff <= rsp_alive_in;
      rsp_oor_ff   <= rsp_oor_in;
      res_alive_ff <= res_alive_in;
      res_oor_ff   <= res_oor_in;
      lat_row_ff   <= lat_row_in;
      lat_col_ff   <= lat_col_in;
      lat_val_ff   <= lat_val_in;
      lat_oor_ff   <= lat_oor_in;
      lat_cmd_ff   <= lat_cmd_in;
      row_cnt_ff   <= row_cnt_in;
      above_ff     <= above_in;
      cur_ff       <= cur_in;
      first_ff     <= first_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_alive_ff};
   assign rsp_tuser  = rsp_oor_ff;

endmodule

// ----- rtl/core/lgs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lgs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/lgs_row_unit.sv -----
// Row update unit: next generation of one board row from its old neighbors.
`timescale 1ns / 1ps

module lgs_row_unit (
   input  lgs_pkg::row_cfg_type             cfg,
   input  logic [lgs_pkg::MAX_COLS-1:0]     above,
   input  logic [lgs_pkg::MAX_COLS-1:0]     cur,
   input  logic [lgs_pkg::MAX_COLS-1:0]     below,
   output logic [lgs_pkg::MAX_COLS-1:0]     next_row
);
   import lgs_pkg::*;

   logic wl_a, wl_c, wl_b;
   logic wr_a, wr_c, wr_b;

   assign wl_a = cfg.wrap & above[cfg.last_col];
   assign wl_c = cfg.wrap & cur[cfg.last_col];
   assign wl_b = cfg.wrap & below[cfg.last_col];
   assign wr_a = cfg.wrap & above[0];
   assign wr_c = cfg.wrap & cur[0];
   assign wr_b = cfg.wrap & below[0];

   for (genvar j = 0; j < MAX_COLS; j++) begin : g_col
      logic       a_l, c_l, b_l;
      logic       a_r, c_r, b_r;
      logic       active;
      logic       is_last;
      logic [3:0] n;

      assign active  = SIZE_W'(j) < cfg.cols;
      assign is_last = SIZE_W'(j + 1) == cfg.cols;

      if (j == 0) begin : g_left_edge
         assign a_l = wl_a;
         assign c_l = wl_c;
         assign b_l = wl_b;
      end else begin : g_left_inner
         assign a_l = above[j-1];
         assign c_l = cur[j-1];
         assign b_l = below[j-1];
      end

      if (j == MAX_COLS - 1) begin : g_right_edge
         assign a_r = wr_a;
         assign c_r = wr_c;
         assign b_r = wr_b;
      end else begin : g_right_inner
         assign a_r = is_last ? wr_a : above[j+1];
         assign c_r = is_last ? wr_c : cur[j+1];
         assign b_r = is_last ? wr_b : below[j+1];
      end

      assign n = 4'(a_l) + 4'(above[j]) + 4'(a_r) + 4'(c_l) + 4'(c_r)
               + 4'(b_l) + 4'(below[j]) + 4'(b_r);

      assign next_row[j] = active
                         ? ((n == 4'(BIRTH_COUNT)) | ((n == 4'(SURVIVE_COUNT)) & cur[j]))
                         : cur[j];
   end

endmodule

// ----- tb/sv/life_generation_step_test.sv -----
// Testbench for the life generation step block: cell writes, reads and B3/S23 steps.
`timescale 1ns / 1ps

module life_generation_step_test;
   import lgs_pkg::*;

   localparam logic [1:0]           CMD_UNUSED   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED   = 2'd3;
   localparam int                   DRAIN_CYCLES = 80;
   localparam int                   DRAIN_LIMIT  = 20000;

   typedef struct packed {
      logic alive;
      logic beyond;
   } cell_reply_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata  = '0;   // row, col, cell_value
   logic [1:0]           req_tuser  = '0;   // command
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;         // cell_alive
   logic                 rsp_tuser;         // out_of_range
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [SIZE_W-1:0]    csr_wdata  = '0;

   logic [MAX_COLS-1:0]  life_board [MAX_ROWS];
   logic [SIZE_W-1:0]    rows_setting;
   logic [SIZE_W-1:0]    cols_setting;
   logic                 wrap_setting;
   cell_reply_type       cell_reply_q [$];
   cell_reply_type       head_reply;

   int mismatch_count = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_request   = 0;
   int hold_left      = 0;

   life_generation_step dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int used_size(input logic [SIZE_W-1:0] v, input int limit);
      if (v == '0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
   endfunction

   function automatic int neighbor_bit(input logic [MAX_COLS-1:0] bits, input int j,
                                       input int cols, input logic wrap);
      int k;
      k = j;
      if (k < 0) begin
         if (!wrap) return 0;
         k = cols - 1;
      end else if (k >= cols) begin
         if (!wrap) return 0;
         k = 0;
      end
      return int'(bits[k]);
   endfunction

   function automatic void advance_generation();
      int                  rows;
      int                  cols;
      int                  n;
      logic [MAX_COLS-1:0] above;
      logic [MAX_COLS-1:0] first_row;
      logic [MAX_COLS-1:0] cur;
      logic [MAX_COLS-1:0] below;
      logic [MAX_COLS-1:0] next_row;
      rows      = used_size(rows_setting, MAX_ROWS);
      cols      = used_size(cols_setting, MAX_COLS);
      first_row = life_board[0];
      above     = wrap_setting ? life_board[rows-1] : '0;
      for (int r = 0; r < rows; r++) begin
         cur = life_board[r];
         if (r + 1 < rows) begin
            below = life_board[r+1];
         end else begin
            below = wrap_setting ? first_row : '0;
         end
         next_row = cur;
         for (int j = 0; j < cols; j++) begin
            n = neighbor_bit(above, j - 1, cols, wrap_setting)
              + neighbor_bit(above, j,     cols, wrap_setting)
              + neighbor_bit(above, j + 1, cols, wrap_setting)
              + neighbor_bit(cur,   j - 1, cols, wrap_setting)
              + neighbor_bit(cur,   j + 1, cols, wrap_setting)
              + neighbor_bit(below, j - 1, cols, wrap_setting)
              + neighbor_bit(below, j,     cols, wrap_setting)
              + neighbor_bit(below, j + 1, cols, wrap_setting);
            if (n == BIRTH_COUNT) begin
               next_row[j] = 1'b1;
            end else if (n != SURVIVE_COUNT) begin
               next_row[j] = 1'b0;
            end
         end
         life_board[r] = next_row;
         above         = cur;
      end
   endfunction

   function automatic cell_reply_type apply_life_command(input logic [1:0] cmd,
                                                         input logic [COORD_W-1:0] row,
                                                         input logic [COORD_W-1:0] col,
                                                         input logic val);
      cell_reply_type reply;
      logic           beyond;
      reply  = '0;
      beyond = (int'(row) >= used_size(rows_setting, MAX_ROWS)) ||
               (int'(col) >= used_size(cols_setting, MAX_COLS));
      case (cmd)
         CMD_WRITE: begin
            if (beyond) reply.beyond = 1'b1;
            else life_board[row][col] = val;
         end
         CMD_STEP: begin
            advance_generation();
         end
         CMD_READ: begin
            if (beyond) reply.beyond = 1'b1;
            else reply.alive = life_board[row][col];
         end
         default: begin
         end
      endcase
      return reply;
   endfunction

   task automatic send_cell_command(input logic [1:0] cmd, input logic [COORD_W-1:0] row,
                                    input logic [COORD_W-1:0] col, input logic val);
      cell_reply_type reply;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {3'b000, val, col, row};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      reply = apply_life_command(cmd, row, col, val);
      cell_reply_q.push_back(reply);
   endtask

   task automatic send_random_command();
      int                 pick;
      int                 rows;
      int                 cols;
      logic [1:0]         cmd;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      rows = used_size(rows_setting, MAX_ROWS);
      cols = used_size(cols_setting, MAX_COLS);
      pick = $urandom_range(99);
      if (pick < 40) cmd = CMD_WRITE;
      else if (pick < 75) cmd = CMD_READ;
      else if (pick < 97) cmd = CMD_STEP;
      else cmd = CMD_UNUSED;
      pick = $urandom_range(99);
      // keep most traffic near the top-left corner so patterns live across steps
      if (pick < 60) begin
         row = COORD_W'($urandom_range((rows < 12 ? rows : 12) - 1));
         col = COORD_W'($urandom_range((cols < 12 ? cols : 12) - 1));
      end else if (pick < 90) begin
         row = COORD_W'($urandom_range(rows - 1));
         col = COORD_W'($urandom_range(cols - 1));
      end else begin
         row = COORD_W'($urandom_range(63));
         col = COORD_W'($urandom_range(63));
      end
      send_cell_command(cmd, row, col, $urandom_range(99) < 45);
   endtask

   task automatic configure_board(input logic [SIZE_W-1:0] rows,
                                  input logic [SIZE_W-1:0] cols, input logic wrap);
      req_tvalid <= 1'b0;
      while (cell_reply_q.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_UNUSED;
      csr_wdata <= SIZE_W'($urandom);
      @(posedge clock);
      csr_index <= CSR_ROWS;
      csr_wdata <= rows;
      @(posedge clock);
      rows_setting = rows;
      csr_index <= CSR_COLS;
      csr_wdata <= cols;
      @(posedge clock);
      cols_setting = cols;
      csr_index <= CSR_WRAP;
      csr_wdata <= {{(SIZE_W-1){1'b0}}, wrap};
      @(posedge clock);
      wrap_setting = wrap;
      csr_we <= 1'b0;
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
         3: begin send_idle_pct = 27; recv_stall_pct = 27; end
         default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
   endtask

   task automatic test_cleared_board();
      send_cell_command(CMD_READ, 6'd0, 6'd0, 1'b0);
      send_cell_command(CMD_READ, 6'd63, 6'd63, 1'b1);
   endtask

   task automatic test_corner_cells();
      send_cell_command(CMD_WRITE, 6'd0, 6'd0, 1'b1);
      send_cell_command(CMD_WRITE, 6'd63, 6'd63, 1'b1);
      send_cell_command(CMD_WRITE, 6'd0, 6'd63, 1'b1);
      send_cell_command(CMD_READ, 6'd0, 6'd63, 1'b0);
      send_cell_command(CMD_READ, 6'd63, 6'd63, 1'b0);
      send_cell_command(CMD_WRITE, 6'd63, 6'd63, 1'b0);
      send_cell_command(CMD_READ, 6'd63, 6'd63, 1'b1);
   endtask

   task automatic test_beyond_size();
      configure_board(7'd5, 7'd7, 1'b0);
      send_cell_command(CMD_WRITE, 6'd5, 6'd0, 1'b1);
      send_cell_command(CMD_WRITE, 6'd0, 6'd7, 1'b1);
      send_cell_command(CMD_READ, 6'd63, 6'd63, 1'b0);
      send_cell_command(CMD_READ, 6'd4, 6'd6, 1'b0);
      send_cell_command(CMD_READ, 6'd0, 6'd0, 1'b0);
   endtask

   task automatic test_blinker();
      configure_board(7'd8, 7'd8, 1'b0);
      send_cell_command(CMD_WRITE, 6'd1, 6'd0, 1'b1);
      send_cell_command(CMD_WRITE, 6'd1, 6'd1, 1'b1);
      send_cell_command(CMD_WRITE, 6'd1, 6'd2, 1'b1);
      send_cell_command(CMD_STEP, 6'd0, 6'd0, 1'b0);
      send_cell_command(CMD_READ, 6'd0, 6'd1, 1'b0);
      send_cell_command(CMD_READ, 6'd2, 6'd1, 1'b0);
   endtask

   task automatic test_unused_command();
      send_cell_command(CMD_UNUSED, 6'd1, 6'd1, 1'b1);
   endtask

   task automatic test_size_extremes();
      configure_board(7'd0, 7'd0, 1'b1);
      send_cell_command(CMD_STEP, 6'd0, 6'd0, 1'b0);
      send_cell_command(CMD_READ, 6'd0, 6'd0, 1'b0);
      configure_board(7'd127, 7'd127, 1'b0);
      send_cell_command(CMD_READ, 6'd63, 6'd0, 1'b0);
   endtask

   task automatic test_output_backpressure();
      configure_board(7'd16, 7'd16, 1'b1);
      set_idling(0);
      hold_request = 400;
      repeat (12) send_random_command();
   endtask

   task automatic run_random_phase(input logic [SIZE_W-1:0] rows,
                                   input logic [SIZE_W-1:0] cols,
                                   input logic wrap, input int mode, input int count);
      configure_board(rows, cols, wrap);
      set_idling(mode);
      repeat (count) send_random_command();
   endtask

   task automatic test_random_phases();
      run_random_phase(7'd64, 7'd64, 1'b0, 0, 170);
      run_random_phase(7'd64, 7'd64, 1'b1, 1, 170);
      run_random_phase(7'd1, 7'd1, 1'b1, 2, 170);
      run_random_phase(7'd2, 7'd3, 1'b1, 3, 170);
      run_random_phase(7'd0, 7'd0, 1'b0, 0, 170);
      run_random_phase(7'd127, 7'd100, 1'b1, 1, 170);
      run_random_phase(SIZE_W'($urandom_range(64, 1)), SIZE_W'($urandom_range(64, 1)),
                       1'($urandom_range(1)), 2, 170);
      run_random_phase(7'd8, 7'd8, 1'b1, 3, 170);
      run_random_phase(SIZE_W'($urandom_range(127)), SIZE_W'($urandom_range(127)),
                       1'($urandom_range(1)), 0, 170);
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cell_reply_q.size() == 0) begin
            $display("%0t: unexpected word: expected none, actual tdata=%h tuser=%b",
                     $time, rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            head_reply = cell_reply_q.pop_front();
            if (rsp_tdata !== {7'd0, head_reply.alive}) begin
               $display("%0t: cell_alive mismatch: expected %h, actual %h",
                        $time, {7'd0, head_reply.alive}, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser !== head_reply.beyond) begin
               $display("%0t: out_of_range mismatch: expected %b, actual %b",
                        $time, head_reply.beyond, rsp_tuser);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #4000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      for (int r = 0; r < MAX_ROWS; r++) life_board[r] = '0;
      rows_setting = SIZE_W'(64);
      cols_setting = SIZE_W'(64);
      wrap_setting = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_cleared_board();
      test_corner_cells();
      test_beyond_size();
      test_blinker();
      test_unused_command();
      test_size_extremes();
      test_output_backpressure();
      test_random_phases();
      req_tvalid <= 1'b0;
      set_idling(0);
      for (int i = 0; i < DRAIN_LIMIT && cell_reply_q.size() != 0; i++) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (cell_reply_q.size() != 0) begin
         $display("%0t: missing words: expected %0d more, actual 0",
                  $time, cell_reply_q.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
